// ===== hdl/owm_pkg.sv =====
package owm_pkg;

    localparam int COUNT_WIDTH = 10;
    localparam int NUM_REGS    = 8;
    localparam int REG_IDX_W   = 3;
    localparam int PHASE_W     = 4;
    localparam int BIT_IDX_W   = 3;
    localparam int TDATA_W     = 16;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE_SMPL  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_RECOVERY = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_LOW      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_HOLD     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_READ_LOW       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_READ_RECOVERY  = 3'd7;

    // command kinds
    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // sequencer phases; phase code minus one is the timing register index
    localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RST_LOW   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RST_WAIT  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RST_RECOV = 4'd3;
    localparam logic [PHASE_W-1:0] PH_WR_LOW    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_WR_HOLD   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RD_LOW    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RD_WAIT   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RD_RECOV  = 4'd8;

    typedef logic [NUM_REGS-1:0][COUNT_WIDTH-1:0] owm_regs_t;

    localparam owm_regs_t REG_DEFAULTS = {
        10'd50, 10'd5, 10'd5, 10'd50, 10'd10, 10'd500, 10'd70, 10'd500
    };

    typedef struct packed {
        logic       line_level;
        logic [7:0] write_byte;
        logic [1:0] operation;
        logic       start_req;
    } owm_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       presence_level;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } owm_result_t;

endpackage

// ===== hdl/owm_cfg_regs.sv =====
module owm_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [owm_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [owm_pkg::COUNT_WIDTH-1:0]   cfg_wdata,
    output owm_pkg::owm_regs_t                regs
);

    owm_pkg::owm_regs_t regs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= owm_pkg::REG_DEFAULTS;
        end else if (cfg_wr_en) begin
            regs_reg[cfg_index] <= cfg_wdata;
        end
    end

    assign regs = regs_reg;

endmodule

// ===== hdl/owm_seq.sv =====
module owm_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  owm_pkg::owm_item_t   item,
    input  owm_pkg::owm_regs_t   regs,
    output owm_pkg::owm_result_t result
);

    logic [owm_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [owm_pkg::COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [owm_pkg::BIT_IDX_W-1:0]   bit_reg, bit_next;
    logic [7:0]                      shift_reg, shift_next;
    logic                            pres_reg, pres_next;
    logic [7:0]                      rbyte_reg, rbyte_next;

    logic [owm_pkg::PHASE_W-1:0]     ph;
    logic [owm_pkg::PHASE_W-1:0]     ph_off;
    logic [owm_pkg::COUNT_WIDTH-1:0] tick_cur;
    logic [owm_pkg::COUNT_WIDTH-1:0] tick_inc;
    logic [owm_pkg::COUNT_WIDTH-1:0] len;
    logic [owm_pkg::BIT_IDX_W-1:0]   bit_cur;
    logic [7:0]                      shift_cur;
    logic                            interval_end;
    logic                            drive, busy, done;

    always_comb begin
        ph        = phase_reg;
        tick_cur  = tick_reg;
        bit_cur   = bit_reg;
        shift_cur = shift_reg;
        // drop unknown phase codes back to idle
        if (ph > owm_pkg::PH_RD_RECOV) begin
            ph = owm_pkg::PH_IDLE;
        end
        if (ph == owm_pkg::PH_IDLE && item.start_req) begin
            case (item.operation)
                owm_pkg::OP_RESET: begin
                    ph       = owm_pkg::PH_RST_LOW;
                    tick_cur = '0;
                    bit_cur  = '0;
                end
                owm_pkg::OP_WRITE: begin
                    ph        = owm_pkg::PH_WR_LOW;
                    tick_cur  = '0;
                    bit_cur   = '0;
                    shift_cur = item.write_byte;
                end
                owm_pkg::OP_READ: begin
                    ph        = owm_pkg::PH_RD_LOW;
                    tick_cur  = '0;
                    bit_cur   = '0;
                    shift_cur = '0;
                end
                default: ;
            endcase
        end

        ph_off       = ph - owm_pkg::PH_RST_LOW;
        len          = regs[ph_off[owm_pkg::REG_IDX_W-1:0]];
        tick_inc     = tick_cur + 1'b1;
        // a zero register acts as one tick; a wrapped count also ends the interval
        interval_end = (tick_inc >= len) || (tick_inc == '0);

        phase_next = ph;
        tick_next  = tick_cur;
        bit_next   = bit_cur;
        shift_next = shift_cur;
        pres_next  = pres_reg;
        rbyte_next = rbyte_reg;
        drive      = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;

        if (ph != owm_pkg::PH_IDLE) begin
            busy = 1'b1;
            case (ph)
                owm_pkg::PH_RST_LOW, owm_pkg::PH_WR_LOW, owm_pkg::PH_RD_LOW: drive = 1'b1;
                owm_pkg::PH_WR_HOLD: drive = ~shift_cur[0];
                default: drive = 1'b0;
            endcase
            tick_next = tick_inc;
            if (interval_end) begin
                tick_next = '0;
                case (ph)
                    owm_pkg::PH_RST_LOW:  phase_next = owm_pkg::PH_RST_WAIT;
                    owm_pkg::PH_RST_WAIT: begin
                        pres_next  = item.line_level;
                        phase_next = owm_pkg::PH_RST_RECOV;
                    end
                    owm_pkg::PH_RST_RECOV: begin
                        done       = 1'b1;
                        phase_next = owm_pkg::PH_IDLE;
                    end
                    owm_pkg::PH_WR_LOW:   phase_next = owm_pkg::PH_WR_HOLD;
                    owm_pkg::PH_WR_HOLD: begin
                        shift_next = {1'b0, shift_cur[7:1]};
                        bit_next   = bit_cur + 1'b1;
                        if (&bit_cur) begin
                            done       = 1'b1;
                            phase_next = owm_pkg::PH_IDLE;
                        end else begin
                            phase_next = owm_pkg::PH_WR_LOW;
                        end
                    end
                    owm_pkg::PH_RD_LOW:   phase_next = owm_pkg::PH_RD_WAIT;
                    owm_pkg::PH_RD_WAIT: begin
                        shift_next = {item.line_level, shift_cur[7:1]};
                        phase_next = owm_pkg::PH_RD_RECOV;
                    end
                    owm_pkg::PH_RD_RECOV: begin
                        bit_next = bit_cur + 1'b1;
                        if (&bit_cur) begin
                            rbyte_next = shift_cur;
                            done       = 1'b1;
                            phase_next = owm_pkg::PH_IDLE;
                        end else begin
                            phase_next = owm_pkg::PH_RD_LOW;
                        end
                    end
                    default: phase_next = owm_pkg::PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= owm_pkg::PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b1;
            rbyte_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
            rbyte_reg <= rbyte_next;
        end
    end

    assign result.drive_low      = drive;
    assign result.busy_res       = busy;
    assign result.done_res       = done;
    assign result.presence_level = pres_next;
    assign result.read_byte      = rbyte_next;

endmodule

// ===== hdl/one_wire_bus_master_core.sv =====
// 1-Wire bus master core.
// Each input beat on the s_ channel is one bus tick (nominally 1 us): it
// carries a command request (start_req, operation, write_byte) and the
// sampled bus level. A request is taken only while idle; the command starts
// on that beat and runs over the following ones; requests meanwhile are ignored.
// Each input beat yields exactly one output beat on the m_ channel with
// drive_low for the open-drain pad, busy/done flags, the last presence
// level and the last read byte.
// The cfg_* port writes the eight 10-bit interval registers (ticks); write
// them only while the core is idle. A value of zero counts as one tick.
// A taken beat waits in the input register and is processed by the sequencer
// as it moves to the output register. Throughput: one beat per cycle while
// m_tready is high, set by the single sequencer pass between the input and output registers.
// When m_tready is low the output register holds its beat, the input
// register fills, and s_tready drops until the output drains.
// Reset (aresetn low, synchronous) returns the sequencer to idle, restores
// the register defaults and empties both stages.
module one_wire_bus_master_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] start_req, [2:1] operation, [10:3] write_byte, [11] line_level
    input  logic [owm_pkg::TDATA_W-1:0]         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence_level,
    // [11:4] read_byte
    output logic [owm_pkg::TDATA_W-1:0]         m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [owm_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [owm_pkg::COUNT_WIDTH-1:0]     cfg_wdata
);

    localparam int ITEM_W = $bits(owm_pkg::owm_item_t);
    localparam int RES_W  = $bits(owm_pkg::owm_result_t);

    owm_pkg::owm_regs_t   regs;
    owm_pkg::owm_item_t   in_reg;
    logic                 in_vld_reg;
    owm_pkg::owm_result_t out_reg;
    owm_pkg::owm_result_t result;
    logic                 out_vld_reg;
    logic                 adv;

    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;

    owm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .regs      (regs)
    );

    owm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (adv),
        .item    (in_reg),
        .regs    (regs),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (adv) begin
                in_vld_reg <= 1'b0;
            end
            if (adv) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= s_tdata[ITEM_W-1:0];
        end
        if (adv) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(owm_pkg::TDATA_W-RES_W){1'b0}}, out_reg};

endmodule

// ===== tb/sv/one_wire_bus_master_core_tb.sv =====
`timescale 1ns / 100ps

import owm_pkg::*;

// Tick-accurate model of the bus sequencer: one expected output beat per tick.
class owm_tick_predictor;
    logic [COUNT_WIDTH-1:0] regs [NUM_REGS];
    logic [PHASE_W-1:0]     seq_phase;
    logic [COUNT_WIDTH-1:0] tick_cnt;
    logic [BIT_IDX_W-1:0]   slot_idx;
    logic [7:0]             shift_reg;
    logic [7:0]             last_read;
    logic                   presence_q;
    owm_result_t            bus_outputs_due [$];
    int                     mismatch_count;

    function new();
        for (int i = 0; i < NUM_REGS; i++) regs[i] = REG_DEFAULTS[i];
        seq_phase      = PH_IDLE;
        tick_cnt       = '0;
        slot_idx       = '0;
        shift_reg      = '0;
        last_read      = '0;
        presence_q     = 1'b1;
        mismatch_count = 0;
    endfunction

    function void set_reg(int idx, logic [COUNT_WIDTH-1:0] val);
        regs[idx] = val;
    endfunction

    function bit busy();
        return seq_phase != PH_IDLE;
    endfunction

    function int pending();
        return bus_outputs_due.size();
    endfunction

    // interval length of a phase; zero counts as one tick
    function logic [COUNT_WIDTH-1:0] interval(logic [PHASE_W-1:0] ph);
        logic [COUNT_WIDTH-1:0] v;
        case (ph)
            PH_RST_LOW:   v = regs[REG_RESET_LOW];
            PH_RST_WAIT:  v = regs[REG_PRESENCE_SMPL];
            PH_RST_RECOV: v = regs[REG_RESET_RECOVERY];
            PH_WR_LOW:    v = regs[REG_WRITE_LOW];
            PH_WR_HOLD:   v = regs[REG_WRITE_HOLD];
            PH_RD_LOW:    v = regs[REG_READ_LOW];
            PH_RD_WAIT:   v = regs[REG_READ_SAMPLE];
            PH_RD_RECOV:  v = regs[REG_READ_RECOVERY];
            default:      v = COUNT_WIDTH'(1);
        endcase
        return (v == '0) ? COUNT_WIDTH'(1) : v;
    endfunction

    function void note_tick(owm_item_t it);
        owm_result_t        r;
        logic [PHASE_W-1:0] ph;
        r = '0;
        if (seq_phase > PH_RD_RECOV) seq_phase = PH_IDLE;
        if (seq_phase == PH_IDLE && it.start_req &&
            (it.operation == OP_RESET || it.operation == OP_WRITE ||
             it.operation == OP_READ)) begin
            tick_cnt = '0;
            slot_idx = '0;
            case (it.operation)
                OP_RESET: seq_phase = PH_RST_LOW;
                OP_WRITE: begin
                    shift_reg = it.write_byte;
                    seq_phase = PH_WR_LOW;
                end
                default: begin
                    shift_reg = '0;
                    seq_phase = PH_RD_LOW;
                end
            endcase
        end
        if (seq_phase != PH_IDLE) begin
            ph = seq_phase;
            r.busy_res = 1'b1;
            case (ph)
                PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: r.drive_low = 1'b1;
                PH_WR_HOLD: r.drive_low = ~shift_reg[0];
                default:    r.drive_low = 1'b0;
            endcase
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= interval(ph) || tick_cnt == '0) begin
                tick_cnt = '0;
                case (ph)
                    PH_RST_LOW: seq_phase = PH_RST_WAIT;
                    PH_RST_WAIT: begin
                        presence_q = it.line_level;
                        seq_phase  = PH_RST_RECOV;
                    end
                    PH_RST_RECOV: begin
                        r.done_res = 1'b1;
                        seq_phase  = PH_IDLE;
                    end
                    PH_WR_LOW: seq_phase = PH_WR_HOLD;
                    PH_WR_HOLD: begin
                        shift_reg = shift_reg >> 1;
                        if (&slot_idx) begin
                            r.done_res = 1'b1;
                            seq_phase  = PH_IDLE;
                        end else begin
                            seq_phase = PH_WR_LOW;
                        end
                        slot_idx = slot_idx + 1'b1;
                    end
                    PH_RD_LOW: seq_phase = PH_RD_WAIT;
                    PH_RD_WAIT: begin
                        // bits arrive LSB first, shift in from the top
                        shift_reg = {it.line_level, shift_reg[7:1]};
                        seq_phase = PH_RD_RECOV;
                    end
                    PH_RD_RECOV: begin
                        if (&slot_idx) begin
                            last_read  = shift_reg;
                            r.done_res = 1'b1;
                            seq_phase  = PH_IDLE;
                        end else begin
                            seq_phase = PH_RD_LOW;
                        end
                        slot_idx = slot_idx + 1'b1;
                    end
                    default: seq_phase = PH_IDLE;
                endcase
            end
        end
        r.presence_level = presence_q;
        r.read_byte      = last_read;
        bus_outputs_due.push_back(r);
    endfunction

    task flag_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task check_bus_output(owm_result_t got);
        owm_result_t want;
        if (bus_outputs_due.size() == 0) begin
            flag_mismatch("unexpected beat", got, 0);
        end else begin
            want = bus_outputs_due.pop_front();
            if (got.drive_low !== want.drive_low)
                flag_mismatch("drive_low", got.drive_low, want.drive_low);
            if (got.busy_res !== want.busy_res)
                flag_mismatch("busy_res", got.busy_res, want.busy_res);
            if (got.done_res !== want.done_res)
                flag_mismatch("done_res", got.done_res, want.done_res);
            if (got.presence_level !== want.presence_level)
                flag_mismatch("presence_level", got.presence_level, want.presence_level);
            if (got.read_byte !== want.read_byte)
                flag_mismatch("read_byte", got.read_byte, want.read_byte);
        end
    endtask

    task close();
        if (bus_outputs_due.size() != 0)
            flag_mismatch("beats never delivered", 0, bus_outputs_due.size());
    endtask
endclass

module one_wire_bus_master_core_tb;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         HOLD_CYCLES   = 250;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         RANDOM_TICKS  = 80;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0]   cfg_index = '0;
    logic [COUNT_WIDTH-1:0] cfg_wdata = '0;

    logic [COUNT_WIDTH-1:0] cfg_vals [NUM_REGS];
    bit                     tx_gaps  = 1'b1;
    bit                     rx_gaps  = 1'b1;
    bit                     hold_req = 1'b0;

    owm_tick_predictor sb = new();

    one_wire_bus_master_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_bus_output(owm_result_t'(m_tdata[$bits(owm_result_t)-1:0]));
    end

    initial begin : result_sink
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // stall the output long enough for the core to back up
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= !(rx_gaps && $urandom_range(99) < 20);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("one_wire_bus_master_core_tb: FAIL");
        $finish;
    end

    // Offer one tick beat; returns at the falling edge after it is taken.
    task automatic send_tick(owm_item_t it);
        while (tx_gaps && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(it);
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(it);
        @(negedge aclk);
    endtask

    function automatic logic line_for(int mode);
        return (mode > 1) ? 1'($urandom_range(1)) : 1'(mode);
    endfunction

    // Start one command, then tick until it completes. line_mode 2 is random.
    task automatic run_command(logic [1:0] op, logic [7:0] wbyte, int line_mode, bit nag);
        owm_item_t it;
        it.start_req  = 1'b1;
        it.operation  = op;
        it.write_byte = wbyte;
        it.line_level = line_for(line_mode);
        send_tick(it);
        while (sb.busy()) begin
            it.start_req  = nag;
            it.operation  = 2'($urandom_range(3));
            it.write_byte = 8'($urandom);
            it.line_level = line_for(line_mode);
            send_tick(it);
        end
    endtask

    task automatic drive_random(int n);
        owm_item_t it;
        repeat (n) begin
            it.write_byte = 8'($urandom);
            it.line_level = 1'($urandom_range(1));
            if (!sb.busy()) begin
                it.start_req = ($urandom_range(99) < 80);
                it.operation = ($urandom_range(19) == 0) ? OP_UNUSED : 2'($urandom_range(2));
            end else begin
                it.start_req = ($urandom_range(99) < 20);
                it.operation = 2'($urandom_range(3));
            end
            send_tick(it);
        end
    endtask

    // Finish the running command, then hold the input until all beats are out.
    task automatic settle();
        owm_item_t it;
        while (sb.busy()) begin
            it            = '0;
            it.line_level = 1'($urandom_range(1));
            send_tick(it);
        end
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One register write beat; leaves the write enable high.
    task automatic write_reg(int idx, logic [COUNT_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_IDX_W'(idx);
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic write_regs();
        for (int i = 0; i < NUM_REGS; i++) begin
            write_reg(i, cfg_vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // shorten four intervals; the other four keep their reset values
        write_reg(REG_RESET_LOW, COUNT_WIDTH'(1));
        write_reg(REG_RESET_RECOVERY, COUNT_WIDTH'(1));
        write_reg(REG_WRITE_HOLD, COUNT_WIDTH'(1));
        write_reg(REG_READ_RECOVERY, COUNT_WIDTH'(1));
        cfg_wr_en <= 1'b0;
        run_command(OP_RESET, 8'h00, 0, 1'b0);
        run_command(OP_WRITE, 8'hA5, 2, 1'b0);
        run_command(OP_READ, 8'h00, 2, 1'b0);
        settle();

        foreach (cfg_vals[i]) cfg_vals[i] = COUNT_WIDTH'(1);
        write_regs();
        run_command(OP_RESET, 8'h00, 1, 1'b0);
        run_command(OP_RESET, 8'h00, 0, 1'b1);
        run_command(OP_WRITE, 8'h00, 2, 1'b0);
        run_command(OP_WRITE, 8'hFF, 2, 1'b1);
        run_command(OP_READ, 8'h00, 1, 1'b0);
        run_command(OP_READ, 8'h00, 0, 1'b1);
        run_command(OP_UNUSED, 8'h5A, 2, 1'b0);
        run_command(OP_READ, 8'hFF, 2, 1'b0);
        settle();

        for (int p = 0; p < 4; p++) begin
            settle();
            foreach (cfg_vals[i]) begin
                case (p)
                    0: cfg_vals[i] = COUNT_WIDTH'($urandom_range(4, 1));
                    1: cfg_vals[i] = '0;
                    2: cfg_vals[i] = COUNT_WIDTH'($urandom_range(12, 1));
                    default: cfg_vals[i] = COUNT_WIDTH'($urandom_range(8));
                endcase
            end
            write_regs();
            case (p)
                0: begin
                    drive_random(RANDOM_TICKS / 2);
                    hold_req = 1'b1;
                    drive_random(RANDOM_TICKS / 2);
                end
                1: begin
                    tx_gaps = 1'b0;
                    rx_gaps = 1'b0;
                    drive_random(RANDOM_TICKS);
                    tx_gaps = 1'b1;
                    rx_gaps = 1'b1;
                end
                2: begin
                    drive_random(RANDOM_TICKS / 2);
                    settle();
                    drive_random(RANDOM_TICKS / 2);
                end
                default: drive_random(RANDOM_TICKS);
            endcase
        end

        settle();

        sb.close();
        if (sb.mismatch_count == 0)
            $display("one_wire_bus_master_core_tb: PASS");
        else
            $display("one_wire_bus_master_core_tb: FAIL");
        $finish;
    end

endmodule
